// ===== rtl/core/imu_pkt_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_pkt_pkg
// Shared types and constants for the sensor packet deframer.
// ----------------------------------------------------------------------------
package imu_pkt_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'h00;
    localparam int         PAYLOAD_LEN = 12;

    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_HDR     = 4'd1;
    localparam logic [3:0] POS_PAYLOAD = 4'd2;
    localparam logic [3:0] POS_LAST    = 4'd13;
    localparam logic [3:0] POS_CHECK   = 4'd14;

    typedef struct packed {
        logic        [7:0]  frame_index;
        logic signed [15:0] angle_raw;
        logic signed [15:0] rate_raw;
        logic signed [15:0] accel_x_raw;
        logic signed [15:0] accel_y_raw;
        logic signed [15:0] accel_z_raw;
        logic        [7:0]  reserved_byte;
        logic               checksum_ok;
    } result_t;

endpackage

// ===== rtl/core/imu_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// imu_packet_deframer
// Splits a received byte stream into 15-byte sensor packets and decodes them.
// ----------------------------------------------------------------------------
// One byte is taken per clock. Bytes are accepted every cycle unless a decoded
// packet sits in the result register and is not being taken in that cycle, the
// single result register being the only thing that throttles input. A packet
// (header 0xAA 0x00, twelve payload bytes, check byte) gives one result in the
// cycle after its check byte transfer; 16-bit fields are little-endian and
// checksum_ok reports the modulo-256 sum of the payload against the check byte.
// ----------------------------------------------------------------------------
module imu_packet_deframer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic        [7:0]  rx_byte,
    output logic               result_valid,
    input  logic               result_ready,
    output logic        [7:0]  frame_index,
    output logic signed [15:0] angle_raw,
    output logic signed [15:0] rate_raw,
    output logic signed [15:0] accel_x_raw,
    output logic signed [15:0] accel_y_raw,
    output logic signed [15:0] accel_z_raw,
    output logic        [7:0]  reserved_byte,
    output logic               checksum_ok
);

    logic                 byte_accept;
    logic                 frame_done;
    logic                 space;
    imu_pkt_pkg::result_t frame_result;
    imu_pkt_pkg::result_t result;

    assign rx_ready    = space;
    assign byte_accept = rx_valid && space;

    imu_pkt_collect u_collect
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_accept  (byte_accept),
        .rx_byte      (rx_byte),
        .frame_done   (frame_done),
        .frame_result (frame_result)
    );

    imu_pkt_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (byte_accept && frame_done),
        .load_result  (frame_result),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .space        (space),
        .result       (result)
    );

    assign frame_index   = result.frame_index;
    assign angle_raw     = result.angle_raw;
    assign rate_raw      = result.rate_raw;
    assign accel_x_raw   = result.accel_x_raw;
    assign accel_y_raw   = result.accel_y_raw;
    assign accel_z_raw   = result.accel_z_raw;
    assign reserved_byte = result.reserved_byte;
    assign checksum_ok   = result.checksum_ok;

endmodule

// ===== rtl/core/imu_pkt_collect.sv =====
// ----------------------------------------------------------------------------
// imu_pkt_collect
// Header hunt, payload capture and checksum; decodes a packet on its check byte.
// ----------------------------------------------------------------------------
module imu_pkt_collect
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    output logic                  frame_done,
    output imu_pkt_pkg::result_t  frame_result
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       shift_en;
    logic [7:0] payload_reg [imu_pkt_pkg::PAYLOAD_LEN];

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        shift_en   = 1'b0;
        frame_done = 1'b0;
        if (pos_reg >= imu_pkt_pkg::POS_PAYLOAD && pos_reg <= imu_pkt_pkg::POS_LAST)
        begin
            shift_en = 1'b1;
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + 4'd1;
        end
        else if (pos_reg == imu_pkt_pkg::POS_CHECK)
        begin
            frame_done = 1'b1;
            pos_next   = imu_pkt_pkg::POS_HUNT;
            sum_next   = 8'd0;
        end
        else if (pos_reg == imu_pkt_pkg::POS_HDR)
        begin
            if (rx_byte == imu_pkt_pkg::HDR_SECOND)
            begin
                pos_next = imu_pkt_pkg::POS_PAYLOAD;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = imu_pkt_pkg::POS_HUNT;
            end
        end
        else
        begin
            // hunting, also the unused position fifteen
            pos_next = (rx_byte == imu_pkt_pkg::HDR_FIRST) ? imu_pkt_pkg::POS_HDR
                                                           : imu_pkt_pkg::POS_HUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= imu_pkt_pkg::POS_HUNT;
            sum_reg <= 8'd0;
        end
        else if (byte_accept)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // payload line: oldest byte ends up in entry 0
    always_ff @(posedge clk)
    begin
        if (byte_accept && shift_en)
        begin
            for (int i = 0; i < imu_pkt_pkg::PAYLOAD_LEN - 1; i++)
            begin
                payload_reg[i] <= payload_reg[i + 1];
            end
            payload_reg[imu_pkt_pkg::PAYLOAD_LEN - 1] <= rx_byte;
        end
    end

    always_comb
    begin
        frame_result.frame_index   = payload_reg[0];
        frame_result.angle_raw     = {payload_reg[2], payload_reg[1]};
        frame_result.rate_raw      = {payload_reg[4], payload_reg[3]};
        frame_result.accel_x_raw   = {payload_reg[6], payload_reg[5]};
        frame_result.accel_y_raw   = {payload_reg[8], payload_reg[7]};
        frame_result.accel_z_raw   = {payload_reg[10], payload_reg[9]};
        frame_result.reserved_byte = payload_reg[11];
        frame_result.checksum_ok   = (sum_reg == rx_byte);
    end

endmodule

// ===== rtl/core/imu_pkt_out.sv =====
// ----------------------------------------------------------------------------
// imu_pkt_out
// Result register; holds a decoded packet until the downstream transfer.
// ----------------------------------------------------------------------------
module imu_pkt_out
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  imu_pkt_pkg::result_t  load_result,
    input  logic                  result_ready,
    output logic                  result_valid,
    output logic                  space,
    output imu_pkt_pkg::result_t  result
);

    logic                 valid_reg;
    logic                 valid_next;
    imu_pkt_pkg::result_t result_reg;

    assign space = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/imu_pkt_checker.sv =====
// ----------------------------------------------------------------------------
// imu_pkt_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module imu_pkt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic        [7:0]  frame_index,
    input logic signed [15:0] angle_raw,
    input logic signed [15:0] rate_raw,
    input logic signed [15:0] accel_x_raw,
    input logic signed [15:0] accel_y_raw,
    input logic signed [15:0] accel_z_raw,
    input logic        [7:0]  reserved_byte,
    input logic               checksum_ok
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(frame_index)
            && $stable(angle_raw) && $stable(rate_raw) && $stable(accel_x_raw)
            && $stable(accel_y_raw) && $stable(accel_z_raw)
            && $stable(reserved_byte) && $stable(checksum_ok))
        else $error("result changed while stalled");

    // input only held off by a full, stalled result register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> result_valid && !result_ready)
        else $error("input stalled without cause");

    // a new result needs a byte transfer
    a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(rx_valid && rx_ready))
        else $error("result appeared without a byte transfer");

    a_next_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready ##1 result_valid |-> $past(rx_valid && rx_ready))
        else $error("back-to-back result without a byte transfer");

endmodule

bind imu_packet_deframer imu_pkt_checker u_imu_pkt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .frame_index   (frame_index),
    .angle_raw     (angle_raw),
    .rate_raw      (rate_raw),
    .accel_x_raw   (accel_x_raw),
    .accel_y_raw   (accel_y_raw),
    .accel_z_raw   (accel_z_raw),
    .reserved_byte (reserved_byte),
    .checksum_ok   (checksum_ok)
);

// ===== tb/imu_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_tb
// Self-checking bench for the sensor packet deframer.
// ----------------------------------------------------------------------------
// Feeds a byte stream of directed header and extreme-value cases, then mostly
// well-formed packets with random payloads and checksums mixed with noise,
// false headers and truncated packets. A scoreboard tracks the packet
// position, payload and running sum and compares every decoded result field
// by field. The sender transfers in random bursts; the receiver stalls on
// its own pattern and holds off for a long stretch every twenty segments.
// ----------------------------------------------------------------------------
module imu_packet_deframer_tb;

    localparam int BYTE_TARGET = 1950;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;

    typedef logic [7:0] frame_body_t [imu_pkt_pkg::PAYLOAD_LEN];

    class deframer_scoreboard;

        logic [3:0]           position;
        logic [7:0]           running_sum;
        logic [7:0]           payload [imu_pkt_pkg::PAYLOAD_LEN];
        imu_pkt_pkg::result_t decoded_q [$];
        int                   errors;

        function new();
            position    = imu_pkt_pkg::POS_HUNT;
            running_sum = 8'h00;
            foreach (payload[i])
                payload[i] = 8'h00;
            errors = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            imu_pkt_pkg::result_t r;
            int                   idx;
            idx = int'(position) - int'(imu_pkt_pkg::POS_PAYLOAD);
            if (position >= imu_pkt_pkg::POS_PAYLOAD && position <= imu_pkt_pkg::POS_LAST)
            begin
                payload[idx] = b;
                running_sum  = running_sum + b;
                position     = position + 4'd1;
            end
            else if (position == imu_pkt_pkg::POS_CHECK)
            begin
                r.frame_index   = payload[0];
                r.angle_raw     = {payload[2], payload[1]};
                r.rate_raw      = {payload[4], payload[3]};
                r.accel_x_raw   = {payload[6], payload[5]};
                r.accel_y_raw   = {payload[8], payload[7]};
                r.accel_z_raw   = {payload[10], payload[9]};
                r.reserved_byte = payload[11];
                r.checksum_ok   = (running_sum == b);
                decoded_q.push_back(r);
                position    = imu_pkt_pkg::POS_HUNT;
                running_sum = 8'h00;
            end
            else if (position == imu_pkt_pkg::POS_HDR)
            begin
                if (b == imu_pkt_pkg::HDR_SECOND)
                begin
                    position    = imu_pkt_pkg::POS_PAYLOAD;
                    running_sum = 8'h00;
                end
                else
                begin
                    position = imu_pkt_pkg::POS_HUNT;
                end
            end
            else
            begin
                position = (b == imu_pkt_pkg::HDR_FIRST) ? imu_pkt_pkg::POS_HDR
                                                         : imu_pkt_pkg::POS_HUNT;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %h, got %h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(imu_pkt_pkg::result_t got);
            imu_pkt_pkg::result_t want;
            if (decoded_q.size() == 0)
            begin
                $error("result with none pending: frame_index %h", got.frame_index);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            compare_field("frame_index", want.frame_index, got.frame_index);
            compare_field("angle_raw", want.angle_raw, got.angle_raw);
            compare_field("rate_raw", want.rate_raw, got.rate_raw);
            compare_field("accel_x_raw", want.accel_x_raw, got.accel_x_raw);
            compare_field("accel_y_raw", want.accel_y_raw, got.accel_y_raw);
            compare_field("accel_z_raw", want.accel_z_raw, got.accel_z_raw);
            compare_field("reserved_byte", want.reserved_byte, got.reserved_byte);
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
        endfunction

    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               rx_valid     = 1'b0;
    logic               rx_ready;
    logic        [7:0]  rx_byte      = 8'h00;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic        [7:0]  frame_index;
    logic signed [15:0] angle_raw;
    logic signed [15:0] rate_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic        [7:0]  reserved_byte;
    logic               checksum_ok;

    deframer_scoreboard sb;
    int                 burst_left  = 0;
    int                 sent_bytes  = 0;
    int                 idle_cycles = 0;

    imu_packet_deframer u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .frame_index   (frame_index),
        .angle_raw     (angle_raw),
        .rate_raw      (rate_raw),
        .accel_x_raw   (accel_x_raw),
        .accel_y_raw   (accel_y_raw),
        .accel_z_raw   (accel_z_raw),
        .reserved_byte (reserved_byte),
        .checksum_ok   (checksum_ok)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // one byte transfer, with a random gap between bursts
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        sb.note_byte(b);
        burst_left--;
        sent_bytes++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return $urandom_range(0, 1) ? 8'h7F : 8'h80;
            3:       return imu_pkt_pkg::HDR_FIRST;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input frame_body_t body, input bit good_sum);
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(imu_pkt_pkg::HDR_FIRST);
        send_byte(imu_pkt_pkg::HDR_SECOND);
        foreach (body[i])
        begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic send_random_frame();
        frame_body_t body;
        foreach (body[i])
            body[i] = pick_byte();
        send_frame(body, $urandom_range(0, 9) < 7);
    endtask

    task automatic send_noise();
        int n;
        int k;
        case ($urandom_range(0, 3))
            0:
            begin
                // false header: second byte wrong
                send_byte(imu_pkt_pkg::HDR_FIRST);
                send_byte(8'($urandom_range(1, 255)));
            end
            1:
            begin
                // truncated packet, the stream then resynchronises on its own
                k = $urandom_range(1, imu_pkt_pkg::PAYLOAD_LEN);
                send_byte(imu_pkt_pkg::HDR_FIRST);
                send_byte(imu_pkt_pkg::HDR_SECOND);
                repeat (k) send_byte(pick_byte());
            end
            default:
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(pick_byte());
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result({frame_index, angle_raw, rate_raw, accel_x_raw,
                             accel_y_raw, accel_z_raw, reserved_byte, checksum_ok});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && rx_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver stall pattern, with a long hold-off every twenty segments
    initial
    begin
        int seg;
        int mode;
        int cyc;
        seg = 0;
        wait (rst_n);
        forever
        begin
            if (seg % 20 == 6)
            begin
                repeat (LONG_HOLD)
                begin
                    result_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                for (cyc = 0; cyc < 64; cyc++)
                begin
                    case (mode)
                        0:       result_ready <= 1'b1;
                        1:       result_ready <= 1'($urandom_range(0, 1));
                        2:       result_ready <= (cyc % 4 == 3);
                        default: result_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    initial
    begin
        frame_body_t extremes;
        sb = new();
        extremes = '{8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF,
                     8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h55};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header mismatch on the second byte
        send_byte(imu_pkt_pkg::HDR_FIRST);
        send_byte(8'h55);
        // a repeated header byte is dropped, not taken as a new start
        send_byte(imu_pkt_pkg::HDR_FIRST);
        send_byte(imu_pkt_pkg::HDR_FIRST);
        send_byte(imu_pkt_pkg::HDR_SECOND);
        // extreme field values with a good checksum
        send_frame(extremes, 1'b1);

        while (sent_bytes < BYTE_TARGET)
        begin
            if ($urandom_range(0, 9) < 8)
                send_random_frame();
            else
                send_noise();
        end
        rx_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== imu_packet_deframer.f =====
rtl/core/imu_pkt_pkg.sv
rtl/core/imu_pkt_collect.sv
rtl/core/imu_pkt_out.sv
rtl/core/imu_packet_deframer.sv
rtl/core/imu_pkt_checker.sv
tb/imu_packet_deframer_tb.sv
